FILE: rtl/core/clr_pkg.sv
// shared types and constants of the cubic lagrange resampler
package clr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int STEP_BITS   = FRAC_BITS + 5;
    localparam int DELAY_BITS  = FRAC_BITS + 1;
    localparam int CFG_BITS    = STEP_BITS;
    localparam int TIME_BITS   = FRAC_BITS + 7;
    localparam int BASE_BITS   = TIME_BITS - FRAC_BITS;
    localparam int COEF_BITS   = SAMPLE_BITS + 6;
    localparam int H_BITS      = SAMPLE_BITS + 8;
    localparam int X_BITS      = FRAC_BITS + 1;
    localparam int DIV_K       = SAMPLE_BITS + 3;
    localparam int B_BITS      = (X_BITS > DIV_K) ? X_BITS : DIV_K;
    localparam int PROD_BITS   = H_BITS + B_BITS;
    localparam int W_BITS      = SAMPLE_BITS + 2;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
    localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(1) << (FRAC_BITS - 4);

    // reciprocal of three, exact for dividends below 2^(DIV_K-1)
    localparam logic signed [B_BITS-1:0] DIV_M = B_BITS'((64'd1 << DIV_K) / 3 + 1);

    // clamp window for floor(w/3) so the quotient lands in the sample range
    localparam logic signed [H_BITS-1:0] W_LO = H_BITS'(-3 * (2 ** (SAMPLE_BITS - 1)));
    localparam logic signed [H_BITS-1:0] W_HI = H_BITS'(3 * (2 ** (SAMPLE_BITS - 1)) - 1);

    // configuration register indexes
    localparam logic REG_STEP  = 1'b0;
    localparam logic REG_DELAY = 1'b1;

    // horner pass codes, one per added coefficient
    localparam logic [1:0] PASS_A2 = 2'd0;
    localparam logic [1:0] PASS_A1 = 2'd1;
    localparam logic [1:0] PASS_A0 = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          final_res;
    } t_out;

    typedef struct packed {
        logic       take;
        logic       load;
        logic       mul;
        logic       add;
        logic [1:0] pass;
        logic       sat;
        logic       div;
        logic       emit;
        logic       final_res;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic last;
        logic out_busy;
    } t_status;

endpackage

FILE: rtl/core/clr_datapath.sv
// window, time accumulator, shared multiplier and output register
module clr_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  clr_pkg::t_in             i_in_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [clr_pkg::CFG_BITS-1:0] i_cfg_data,
    input  clr_pkg::t_cmd            i_cmd,
    output clr_pkg::t_status         o_status,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output clr_pkg::t_out            o_out_data
);
    import clr_pkg::*;

    localparam int D_BITS = BASE_BITS + 1;
    localparam logic signed [TIME_BITS-1:0] T_ONE       = TIME_BITS'(2 ** FRAC_BITS);
    localparam logic signed [TIME_BITS-1:0] T_MINUS_ONE = -T_ONE;
    localparam logic signed [PROD_BITS-1:0] P_HALF      = PROD_BITS'(2 ** (FRAC_BITS - 1));
    localparam logic signed [H_BITS-1:0]    H_THREE     = H_BITS'(3);

    logic [STEP_BITS-1:0]          r_step;
    logic signed [DELAY_BITS-1:0]  r_delay;
    logic signed [DELAY_BITS-1:0]  r_delay_held;
    logic                          r_active;
    logic                          r_last;
    logic signed [TIME_BITS-1:0]   r_time;
    logic signed [SAMPLE_BITS-1:0] r_win [4];
    logic signed [COEF_BITS-1:0]   r_a0;
    logic signed [COEF_BITS-1:0]   r_a1;
    logic signed [COEF_BITS-1:0]   r_a2;
    logic signed [X_BITS-1:0]      r_x;
    logic signed [H_BITS-1:0]      r_h;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic [W_BITS-1:0]             r_w;
    logic                          r_out_valid;
    t_out                          r_out;

    logic [STEP_BITS-1:0]          step_eff;
    logic signed [BASE_BITS-1:0]   base;
    logic signed [D_BITS-1:0]      tap_d [4];
    logic signed [COEF_BITS-1:0]   z [4];
    logic signed [COEF_BITS-1:0]   d30;
    logic signed [COEF_BITS-1:0]   d12;
    logic signed [COEF_BITS-1:0]   d31;
    logic signed [COEF_BITS-1:0]   d32;
    logic signed [COEF_BITS-1:0]   a3;
    logic signed [COEF_BITS-1:0]   a1;
    logic signed [COEF_BITS-1:0]   a2;
    logic signed [COEF_BITS-1:0]   a0;
    logic signed [H_BITS-1:0]      mul_a;
    logic signed [B_BITS-1:0]      mul_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   rnd_full;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [H_BITS-1:0]      h_add;
    logic signed [H_BITS-1:0]      w_half;
    logic signed [H_BITS-1:0]      w_cl;
    logic signed [H_BITS-1:0]      w_off;
    logic signed [TIME_BITS:0]     t_sum;
    logic [SAMPLE_BITS-1:0]        quot;

    assign step_eff = (r_step < STEP_MIN) ? STEP_MIN : r_step;
    assign base     = r_time[TIME_BITS-1:FRAC_BITS];

    // pick the four taps around the output time, zero outside the window
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tap_d[k] = D_BITS'(1 - k) - {base[BASE_BITS-1], base};
            if (tap_d[k][D_BITS-1:2] == '0) begin
                z[k] = COEF_BITS'(r_win[tap_d[k][1:0]]);
            end else begin
                z[k] = '0;
            end
        end
    end

    // farrow coefficients scaled by six
    always_comb begin
        d30 = z[3] - z[0];
        d12 = z[1] - z[2];
        d31 = z[3] - z[1];
        d32 = z[3] - z[2];
        a3  = d30 + (d12 <<< 1) + d12;
        a1  = (d31 <<< 1) + d31 - a3;
        a2  = (d32 <<< 2) + (d32 <<< 1) - a3 - a1;
        a0  = (z[2] <<< 2) + (z[2] <<< 1);
    end

    // shared multiplier: horner product or reciprocal divide by three
    always_comb begin
        if (i_cmd.div) begin
            mul_a = signed'(H_BITS'(r_w));
            mul_b = DIV_M;
        end else begin
            mul_a = r_h;
            mul_b = B_BITS'(r_x);
        end
        prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    always_comb begin
        case (i_cmd.pass)
            PASS_A2: coef = r_a2;
            PASS_A1: coef = r_a1;
            default: coef = r_a0;
        endcase
        rnd_full = (r_prod + P_HALF) >>> FRAC_BITS;
        h_add    = rnd_full[H_BITS-1:0] + H_BITS'(coef);
    end

    // floor((h+3)/6) = floor(floor((h+3)/2)/3), clamped and offset to unsigned
    always_comb begin
        w_half = (r_h + H_THREE) >>> 1;
        if (w_half < W_LO) begin
            w_cl = W_LO;
        end else if (w_half > W_HI) begin
            w_cl = W_HI;
        end else begin
            w_cl = w_half;
        end
        w_off = w_cl - W_LO;
    end

    assign quot = r_prod[DIV_K +: SAMPLE_BITS];

    always_comb begin
        t_sum = (TIME_BITS + 1)'(r_time) + (TIME_BITS + 1)'(r_delay_held);
        if (r_last) begin
            o_status.go = t_sum[TIME_BITS] || (t_sum == '0);
        end else begin
            o_status.go = r_time < T_MINUS_ONE;
        end
        o_status.last     = r_last;
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_delay     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_STEP:  r_step  <= i_cfg_data[STEP_BITS-1:0];
                    REG_DELAY: r_delay <= i_cfg_data[DELAY_BITS-1:0];
                endcase
            end
            if (i_cmd.take) begin
                r_active <= !i_in_data.last;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_last <= i_in_data.last;
            if (r_active) begin
                r_win[3] <= r_win[2];
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_time   <= r_time - T_ONE;
            end else begin
                // stream start: fresh window, delay latched
                r_win[3]     <= '0;
                r_win[2]     <= '0;
                r_win[1]     <= '0;
                r_delay_held <= r_delay;
                r_time       <= -TIME_BITS'(r_delay);
            end
            r_win[0] <= i_in_data.sample;
        end
        if (i_cmd.load) begin
            r_x    <= {1'b1, r_time[FRAC_BITS-1:0]};
            r_h    <= H_BITS'(a3);
            r_a2   <= a2;
            r_a1   <= a1;
            r_a0   <= a0;
            r_time <= r_time + signed'(TIME_BITS'(step_eff));
        end
        if (i_cmd.mul || i_cmd.div) begin
            r_prod <= prod;
        end
        if (i_cmd.add) begin
            r_h <= h_add;
        end
        if (i_cmd.sat) begin
            r_w <= w_off[W_BITS-1:0];
        end
        if (i_cmd.emit) begin
            r_out.value     <= signed'({~quot[SAMPLE_BITS-1], quot[SAMPLE_BITS-2:0]});
            r_out.final_res <= i_cmd.final_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/clr_controller.sv
// sequencer for sample intake and per-output cubic evaluation
module clr_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  clr_pkg::t_status i_status,
    output clr_pkg::t_cmd    o_cmd
);
    import clr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_SAT   = 3'd5;
    localparam logic [2:0] S_DIVM  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_RESULTS);

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;
    logic [1:0]          r_pass;
    logic [1:0]          n_pass;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.go && r_cnt != CNT_MAX) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                n_pass     = PASS_A2;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_pass == PASS_A0) begin
                    n_state = S_SAT;
                end else begin
                    n_pass  = r_pass + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_DIVM;
            end
            S_DIVM: begin
                o_cmd.div = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // go already reflects the advanced output time
                if (!i_status.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.final_res = i_status.last && (!i_status.go || r_cnt == CNT_MAX);
                    n_state         = S_CHECK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= PASS_A2;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

endmodule

FILE: rtl/core/cubic_lagrange_resampler.sv
// top level of the cubic lagrange resampler
//
// input channel: one sample per transfer (i_in_valid / o_in_ready), with a
// last flag on the final sample of a stream. output channel: interpolated
// samples (o_out_valid / i_out_ready), final_res set on the stream's last one.
// config port: i_cfg_we writes step (index 0, unsigned Q16) or frac_delay
// (index 1, signed Q16); write only while the block is idle.
// each input transfer goes through intake and check, and each result it
// releases then runs in turn: coefficient load, three multiply/add horner
// rounds, saturation, reciprocal multiply for the divide by six, output
// write; the steps share a single multiplier. results per sample follow from
// step, at most 64, and the last sample flushes the remaining outputs.
// o_in_ready is high only while no sample is being worked on.
// reset clears the stream state and loads step = 1.0 and delay = 0.
// the output register holds a result until taken; while it is stalled the
// sequencer waits before writing the next result, and a new sample can be
// taken while the final result of the previous one still waits.
module cubic_lagrange_resampler (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  clr_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output clr_pkg::t_out            o_out_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [clr_pkg::CFG_BITS-1:0] i_cfg_data
);
    import clr_pkg::*;

    t_cmd    cmd;
    t_status status;

    clr_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    clr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/clr_checker.sv
// port-level checks for the resampler and their binding
module clr_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input clr_pkg::t_out            o_out_data
);
    import clr_pkg::*;

    // a result stays offered until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // a taken sample keeps the intake closed in the next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("intake open right after a sample transfer");

    // results are only written while a sample is in work
    a_out_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result appeared while intake was open");

endmodule

bind cubic_lagrange_resampler clr_checker u_clr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/testbench.sv
// self-checking testbench for the cubic lagrange resampler
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam longint ONE_T = longint'(1) << FRAC_BITS;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP = 60;

    class resample_scoreboard;
        logic [STEP_BITS-1:0] step_reg;
        logic signed [DELAY_BITS-1:0] delay_reg;
        longint window[4];
        logic [23:0] taken;
        longint out_time;
        longint delay_latched;
        t_out pending_outputs[$];
        int errors;

        function new();
            step_reg = STEP_RESET;
            delay_reg = '0;
            window = '{default: 0};
            taken = '0;
            out_time = 0;
            delay_latched = 0;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_BITS-1:0] data);
            if (idx == REG_STEP) begin
                step_reg = data[STEP_BITS-1:0];
            end else begin
                delay_reg = data[DELAY_BITS-1:0];
            end
        endfunction

        // samples outside the window read as zero
        function longint tap(longint d);
            return (d >= 0 && d <= 3) ? window[int'(d)] : 0;
        endfunction

        function longint round_q(longint v);
            return (v + (ONE_T >>> 1)) >>> FRAC_BITS;
        endfunction

        function logic signed [SAMPLE_BITS-1:0] cubic_at(longint rel);
            longint base, x, z0, z1, z2, z3, a0, a1, a2, a3, h, u, q, hi, lo;
            base = rel >>> FRAC_BITS;
            x = (rel & (ONE_T - 1)) - ONE_T;
            z0 = tap(1 - base);
            z1 = tap(-base);
            z2 = tap(-1 - base);
            z3 = tap(-2 - base);
            // six times the farrow coefficients
            a3 = (z3 - z0) + 3 * (z1 - z2);
            a1 = 3 * (z3 - z1) - a3;
            a2 = 6 * (z3 - z2) - a3 - a1;
            a0 = 6 * z2;
            h = round_q(a3 * x) + a2;
            h = round_q(h * x) + a1;
            h = round_q(h * x) + a0;
            u = h + 3;
            q = u / 6;
            if (u < 0 && (u % 6) != 0) q = q - 1;
            hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return SAMPLE_BITS'(q);
        endfunction

        function void take_sample(t_in item);
            longint st;
            int n;
            bit go;
            t_out held;
            st = longint'(step_reg);
            if (st < longint'(STEP_MIN)) st = longint'(STEP_MIN);
            if (taken == 0) begin
                window = '{default: 0};
                delay_latched = longint'(delay_reg);
                out_time = -delay_latched;
            end else begin
                out_time -= ONE_T;
            end
            window[3] = window[2];
            window[2] = window[1];
            window[1] = window[0];
            window[0] = longint'($signed(item.sample));
            n = 0;
            held = '0;
            while (n < MAX_RESULTS) begin
                go = item.last ? (out_time + delay_latched <= 0) : (out_time < -ONE_T);
                if (!go) break;
                // push one behind so the flush mark lands on the last result
                if (n > 0) pending_outputs.push_back(held);
                held.value = cubic_at(out_time);
                held.final_res = 1'b0;
                n++;
                out_time += st;
            end
            if (n > 0) begin
                held.final_res = item.last;
                pending_outputs.push_back(held);
            end
            if (item.last) begin
                taken = '0;
            end else if (taken != '1) begin
                taken++;
            end
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
        endtask

        task check_output(t_out got);
            t_out want;
            if (pending_outputs.size() == 0) begin
                flag_mismatch($sformatf("unexpected output value %0d final_res %0b",
                                        got.value, got.final_res));
                return;
            end
            want = pending_outputs.pop_front();
            if (got.value !== want.value)
                flag_mismatch($sformatf("value got %0d want %0d", got.value, want.value));
            if (got.final_res !== want.final_res)
                flag_mismatch($sformatf("final_res got %0b want %0b (value %0d)",
                                        got.final_res, want.final_res, want.value));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = REG_STEP;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    resample_scoreboard sb = new();
    int burst_left = 0;
    int stall_left = 0;
    int rx_cycle = 0;

    cubic_lagrange_resampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // receiver: stall density cycles through none, light and heavy
    always @(posedge i_clk) begin
        int level;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_output(o_out_data);
        rx_cycle <= rx_cycle + 1;
        level = (rx_cycle / 300) % 3;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (level != 0 && $urandom_range(0, 3) < level) begin
            stall_left <= $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic put_sample(logic signed [SAMPLE_BITS-1:0] value, logic last);
        t_in item;
        item.sample = value;
        item.last = last;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(item);
        // sender works in bursts; valid stays up inside a burst
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_BITS-1:0] step_val, logic [CFG_BITS-1:0] delay_val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_STEP;
        i_cfg_data <= step_val;
        @(posedge i_clk);
        sb.write_reg(REG_STEP, step_val);
        i_cfg_idx <= REG_DELAY;
        i_cfg_data <= delay_val;
        @(posedge i_clk);
        sb.write_reg(REG_DELAY, delay_val);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_step();
        case ($urandom_range(0, 3))
            0: return CFG_BITS'($urandom_range(4096, 32768));
            1: return CFG_BITS'($urandom_range(32768, 131072));
            2: return CFG_BITS'($urandom_range(131072, 1048576));
            default: return CFG_BITS'($urandom_range(60000, 71000));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_delay();
        return CFG_BITS'(int'($urandom_range(0, 131070)) - 65535);
    endfunction

    // streams of random length; most end with last, a few run on into the next
    task automatic random_phase(int items);
        int left, len;
        bit close;
        left = items;
        while (left > 0) begin
            len = $urandom_range(1, 16);
            if (len > left) len = left;
            close = ($urandom_range(0, 7) != 0);
            for (int k = 0; k < len; k++) put_sample(pick_sample(), close && k == len - 1);
            left -= len;
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // reset settings: unit step, zero delay, full-scale swings
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh0000, 1'b0);
        put_sample(16'sh0001, 1'b0);
        put_sample(16'shFFFF, 1'b0);
        put_sample(16'sh7FFF, 1'b1);
        // a stream of a single sample
        put_sample(16'sh8000, 1'b1);
        wait_idle();

        // step below 1/16 is raised to 1/16, delay near +1, overshoot saturates
        set_config('0, CFG_BITS'(65535));
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh7FFF, 1'b1);
        wait_idle();

        // largest step the register holds, delay near -1
        set_config('1, CFG_BITS'(-65535));
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh7FFF, 1'b0);
        put_sample(16'sh8000, 1'b0);
        put_sample(16'sh0000, 1'b1);
        wait_idle();

        // step and delay rewritten in the middle of a stream
        set_config(CFG_BITS'(98304), CFG_BITS'(32768));
        put_sample(16'sh1234, 1'b0);
        put_sample(16'shC000, 1'b0);
        put_sample(16'sh4000, 1'b0);
        wait_idle();
        set_config(CFG_BITS'(45000), CFG_BITS'(-20000));
        put_sample(16'sh2000, 1'b0);
        put_sample(16'shE000, 1'b0);
        put_sample(16'sh7000, 1'b1);
        wait_idle();

        set_config(CFG_BITS'(4096), CFG_BITS'(65535));
        random_phase(24);
        set_config(CFG_BITS'(1048576), CFG_BITS'(-65535));
        random_phase(24);
        repeat (4) begin
            set_config(pick_step(), pick_delay());
            random_phase(24);
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
